### rtl/core/kgr_pkg.sv
// ----------------------------------------------------------------------------
// kgr_pkg
// shared constants and types for the k-group stream reverser
// ----------------------------------------------------------------------------
`default_nettype none

package kgr_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned GSIZE_W      = 5;
	localparam int unsigned MAX_GROUP    = 16;
	localparam int unsigned GSIZE_RESET  = 1;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_FILL = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

endpackage

`default_nettype wire

### rtl/core/kgr_cell.sv
// ----------------------------------------------------------------------------
// kgr_cell
// one storage cell of the group chain, takes its left or right neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module kgr_cell (
	input  wire logic                             clk,
	input  wire kgr_pkg::cell_ctrl_t              ctrl,
	input  wire logic [kgr_pkg::DATA_W-1:0]       left_data,
	input  wire logic [kgr_pkg::DATA_W-1:0]       right_data,
	output logic      [kgr_pkg::DATA_W-1:0]       data
);

	logic [kgr_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			data_q <= left_data;
		end else if (ctrl.shift_down) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

### rtl/core/stream_k_group_reverser.sv
// ----------------------------------------------------------------------------
// stream_k_group_reverser
// buffers list values into groups and emits each full group newest first
// ----------------------------------------------------------------------------
// s_axis carries one list value per beat, tlast marks the end of the list.
// m_axis carries the reordered values: tlast marks the last beat caused by
// one input beat, tuser marks the final beat of the whole list.
// cfg_wr_en/cfg_wr_data set the group size (0 acts as 1, above MaxGroup
// saturates); write it only while the block is idle.
// Values enter a chain of cells, one beat per cycle while a group fills.
// A full group leaves newest first, shifted out of the head cell one beat a
// cycle while m_axis accepts; a partial group at list end leaves oldest first.
// While a run of results drains the input is held off, so each group is
// filled, then drained through the output register before the next fills.
// The closing beat sets the emit state; then the first result is registered.
// A stall on m_axis freezes the drain; the output register holds its beat.
// Reset marks the chain empty, drops the output valid and sets group size to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_k_group_reverser #(
	parameter int unsigned MaxGroup = kgr_pkg::MAX_GROUP
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [kgr_pkg::GSIZE_W-1:0]      cfg_wr_data,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [kgr_pkg::DATA_W-1:0]       s_axis_tdata,  // data_value
	input  wire logic                             s_axis_tlast,  // list_end
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic      [kgr_pkg::DATA_W-1:0]       m_axis_tdata,  // out_value
	output logic                                  m_axis_tlast,  // run_last
	output logic                                  m_axis_tuser   // out_list_end
);

	localparam int unsigned CntW = $clog2(MaxGroup + 1);
	localparam int unsigned IdxW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;
	localparam int unsigned EffW = (CntW > kgr_pkg::GSIZE_W) ? CntW : kgr_pkg::GSIZE_W;

	kgr_pkg::state_t state_q;
	logic [kgr_pkg::GSIZE_W-1:0] gsize_q;
	logic [CntW-1:0] fill_q;
	logic [CntW-1:0] cnt_q;
	logic rev_q;
	logic list_end_q;

	logic m_valid_q;
	logic [kgr_pkg::DATA_W-1:0] m_data_q;
	logic m_last_q;
	logic m_user_q;

	logic [kgr_pkg::DATA_W-1:0] cell_data [MaxGroup];
	kgr_pkg::cell_ctrl_t cell_ctrl;

	logic in_beat;
	logic out_free;
	logic emit_go;
	logic [EffW-1:0] eff_size;
	logic [EffW-1:0] n_next;
	logic [IdxW-1:0] rd_idx;
	logic [kgr_pkg::DATA_W-1:0] fwd_data;
	logic [kgr_pkg::DATA_W-1:0] emit_data;

	// effective group size
	always_comb begin
		if (gsize_q == '0) begin
			eff_size = EffW'(1);
		end else if (EffW'(gsize_q) > EffW'(MaxGroup)) begin
			eff_size = EffW'(MaxGroup);
		end else begin
			eff_size = EffW'(gsize_q);
		end
	end

	assign s_axis_tready = (state_q == kgr_pkg::ST_FILL);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign emit_go       = (state_q == kgr_pkg::ST_EMIT) && out_free;
	assign n_next        = EffW'(fill_q) + EffW'(1);

	always_comb begin
		cell_ctrl.shift_up   = in_beat;
		cell_ctrl.shift_down = emit_go && rev_q;
	end

	// cell chain, head cell holds the newest value
	for (genvar i = 0; i < MaxGroup; i++) begin : g_cell
		logic [kgr_pkg::DATA_W-1:0] left_d;
		logic [kgr_pkg::DATA_W-1:0] right_d;
		if (i == 0) begin : g_head
			assign left_d = s_axis_tdata;
		end else begin : g_body
			assign left_d = cell_data[i-1];
		end
		if (i == MaxGroup - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end
		kgr_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	// oldest-first read of a partial group
	assign rd_idx = IdxW'(cnt_q - CntW'(1));

	always_comb begin
		fwd_data = '0;
		for (int i = 0; i < MaxGroup; i++) begin
			if (rd_idx == IdxW'(i)) begin
				fwd_data = cell_data[i];
			end
		end
	end

	assign emit_data = rev_q ? cell_data[0] : fwd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= kgr_pkg::GSIZE_W'(kgr_pkg::GSIZE_RESET);
		end else if (cfg_wr_en) begin
			gsize_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kgr_pkg::ST_FILL;
			fill_q     <= '0;
			cnt_q      <= '0;
			rev_q      <= 1'b0;
			list_end_q <= 1'b0;
		end else begin
			unique case (state_q)
				kgr_pkg::ST_FILL: begin
					if (in_beat) begin
						if (n_next >= eff_size) begin
							state_q    <= kgr_pkg::ST_EMIT;
							cnt_q      <= CntW'(n_next);
							rev_q      <= 1'b1;
							list_end_q <= s_axis_tlast;
						end else if (s_axis_tlast) begin
							state_q    <= kgr_pkg::ST_EMIT;
							cnt_q      <= CntW'(n_next);
							rev_q      <= 1'b0;
							list_end_q <= 1'b1;
						end else begin
							fill_q <= CntW'(n_next);
						end
					end
				end
				kgr_pkg::ST_EMIT: begin
					if (emit_go) begin
						cnt_q <= cnt_q - CntW'(1);
						if (cnt_q == CntW'(1)) begin
							state_q <= kgr_pkg::ST_FILL;
							fill_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= kgr_pkg::ST_FILL;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_data_q <= emit_data;
			m_last_q <= (cnt_q == CntW'(1));
			m_user_q <= (cnt_q == CntW'(1)) && list_end_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire
